// ===== rtl/core/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text mode console writer: request,
// response and internal command formats, character codes and op codes.
// ----------------------------------------------------------------------------
package tmcw_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] RESET_ATTRIBUTE = 8'h1F;
   localparam logic [7:0] SPACE_CODE      = 8'h20;
   localparam logic [7:0] LAST_PRINTABLE  = 8'h7F;
   localparam logic [7:0] CHAR_BS         = 8'h08;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef logic [2:0] kind_type;

   localparam kind_type K_NOP   = 3'd0;
   localparam kind_type K_PRINT = 3'd1;
   localparam kind_type K_BS    = 3'd2;
   localparam kind_type K_TAB   = 3'd3;
   localparam kind_type K_CR    = 3'd4;
   localparam kind_type K_LF    = 3'd5;
   localparam kind_type K_CLEAR = 3'd6;
   localparam kind_type K_READ  = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [10:0] read_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_index;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_code;
      logic [10:0] read_index;
   } cmd_type;

endpackage

// ===== rtl/core/tmcw_front.sv =====
// ----------------------------------------------------------------------------
// tmcw_front
// Command front end: accepts request beats and classifies them into
// internal commands for the command queue.
// ----------------------------------------------------------------------------
module tmcw_front #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS
) (
   input  logic              start,
   output logic              busy,
   input  tmcw_pkg::req_type req_payload,
   input  logic              queue_full,
   input  logic              init_active,
   output logic              push,
   output tmcw_pkg::cmd_type cmd
);
   import tmcw_pkg::*;

   localparam int          CELLS   = COLUMNS * ROWS;
   localparam logic [31:0] CELLS_U = 32'(CELLS);

   logic [31:0] index_wide;

   assign busy       = init_active | queue_full;
   assign push       = start & ~busy;
   assign index_wide = 32'(req_payload.read_index);

   always_comb begin
      cmd.char_code  = req_payload.char_code;
      cmd.read_index = req_payload.read_index;
      case (req_payload.op)
         OP_PUT: begin
            case (req_payload.char_code)
               CHAR_BS:  cmd.kind = K_BS;
               CHAR_TAB: cmd.kind = K_TAB;
               CHAR_CR:  cmd.kind = K_CR;
               CHAR_LF:  cmd.kind = K_LF;
               default: begin
                  if (req_payload.char_code inside {[SPACE_CODE:LAST_PRINTABLE]}) begin
                     cmd.kind = K_PRINT;
                  end else begin
                     cmd.kind = K_NOP;
                  end
               end
            endcase
         end
         OP_CLEAR: cmd.kind = K_CLEAR;
         OP_READ: begin
            if (index_wide < CELLS_U) begin
               cmd.kind = K_READ;
            end else begin
               cmd.kind = K_NOP;
            end
         end
         default: cmd.kind = K_NOP;
      endcase
   end

endmodule

// ===== rtl/core/tmcw_queue.sv =====
// ----------------------------------------------------------------------------
// tmcw_queue
// Short command queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
module tmcw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tmcw_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              head_valid,
   output tmcw_pkg::cmd_type head_cmd,
   output logic              full
);
   import tmcw_pkg::*;

   localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PW-1:0]   LAST_PTR  = PW'(QUEUE_DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(QUEUE_DEPTH);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == FULL_CNT);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command popped from empty queue");

endmodule

// ===== rtl/core/tmcw_back.sv =====
// ----------------------------------------------------------------------------
// tmcw_back
// Execution engine: owns the cell store and the cursor, runs the reset
// clearing pass, character writes, cell reads, screen clears and scrolls.
// ----------------------------------------------------------------------------
module tmcw_back #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        attribute,
   input  logic              q_valid,
   input  tmcw_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              init_active,
   output logic              rsp_strobe,
   output tmcw_pkg::rsp_type rsp_payload
);
   import tmcw_pkg::*;

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int AW        = $clog2(CELLS);
   localparam int CW        = $clog2(COLUMNS + 8);
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

   localparam logic [AW-1:0] LAST_A = AW'(LAST_BASE);
   localparam logic [AW-1:0] COL_A  = AW'(COLUMNS);
   localparam logic [AW-1:0] END_A  = AW'(CELLS - 1);
   localparam logic [CW-1:0] COLS_C = CW'(COLUMNS);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_CLEAR  = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;

   logic [15:0]   text_store_ff [CELLS];
   logic [15:0]   rd_data_ff;

   logic [2:0]    state_ff;
   logic [2:0]    state_in;
   logic [AW-1:0] cnt_ff;
   logic [AW-1:0] cnt_in;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [AW-1:0] rowbase_ff;
   logic [AW-1:0] rowbase_in;
   logic          pw_valid_ff;
   logic          pw_valid_in;
   logic          pw_copy_ff;
   logic          pw_copy_in;
   logic [AW-1:0] pw_addr_ff;
   logic [AW-1:0] pw_addr_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] ncol;
   logic          newline;
   logic [AW-1:0] lin;
   logic [31:0]   lin_wide;
   logic [31:0]   index_wide;

   assign init_active = (state_ff == S_INIT);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign index_wide  = 32'(q_cmd.read_index);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      rowbase_in   = rowbase_ff;
      pw_valid_in  = 1'b0;
      pw_copy_in   = pw_copy_ff;
      pw_addr_in   = pw_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = {RESET_ATTRIBUTE, SPACE_CODE};
      rd_addr      = cnt_ff;
      ncol         = col_ff;
      newline      = 1'b0;

      case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == END_A) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  K_READ: begin
                     rd_addr  = index_wide[AW-1:0];
                     state_in = S_READ;
                  end
                  K_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     case (q_cmd.kind)
                        K_PRINT: begin
                           mem_we    = 1'b1;
                           mem_waddr = rowbase_ff + AW'(col_ff);
                           mem_wdata = {attribute, q_cmd.char_code};
                           ncol      = col_ff + CW'(1);
                        end
                        K_BS:    ncol = (col_ff == '0) ? '0 : col_ff - CW'(1);
                        K_TAB:   ncol = (col_ff + CW'(8)) & ~CW'(7);
                        K_CR:    ncol = '0;
                        K_LF: begin
                           ncol    = '0;
                           newline = 1'b1;
                        end
                        default: ncol = col_ff;
                     endcase
                     if (ncol >= COLS_C) begin
                        ncol    = '0;
                        newline = 1'b1;
                     end
                     col_in = ncol;
                     if (newline && (rowbase_ff == LAST_A)) begin
                        cnt_in   = '0;
                        state_in = S_SCROLL;
                     end else begin
                        if (newline) begin
                           rowbase_in = rowbase_ff + COL_A;
                        end
                        rsp_valid_in       = 1'b1;
                        rsp_in.cell_value  = '0;
                        rsp_in.scrolled    = 1'b0;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_in.cell_value = rd_data_ff;
            rsp_in.scrolled   = 1'b0;
            state_in          = S_IDLE;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {attribute, SPACE_CODE};
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == END_A) begin
               cnt_in            = '0;
               col_in            = '0;
               rowbase_in        = '0;
               rsp_valid_in      = 1'b1;
               rsp_in.cell_value = '0;
               rsp_in.scrolled   = 1'b0;
               state_in          = S_IDLE;
            end
         end
         S_SCROLL: begin
            pw_valid_in = 1'b1;
            pw_addr_in  = cnt_ff;
            pw_copy_in  = (cnt_ff < LAST_A);
            rd_addr     = pw_copy_in ? cnt_ff + COL_A : cnt_ff;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == END_A) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            rsp_valid_in      = 1'b1;
            rsp_in.cell_value = '0;
            rsp_in.scrolled   = 1'b1;
            state_in          = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // retire the delayed scroll write
      if (pw_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pw_addr_ff;
         mem_wdata = pw_copy_ff ? rd_data_ff : {attribute, SPACE_CODE};
      end

      lin      = rowbase_in + AW'(col_in);
      lin_wide = 32'(lin);
      if (rsp_valid_in) begin
         rsp_in.cursor_index = lin_wide[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         rowbase_ff   <= '0;
         pw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         rowbase_ff   <= rowbase_in;
         pw_valid_ff  <= pw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pw_copy_ff <= pw_copy_in;
      pw_addr_ff <= pw_addr_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_store_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= text_store_ff[rd_addr];
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < COLS_C)
      else $error("cursor column out of range");

   a_rowbase_in_range: assert property (@(posedge clock) disable iff (reset)
      rowbase_ff <= LAST_A)
      else $error("cursor row out of range");

   a_scroll_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pw_valid_ff |-> (state_ff == S_SCROLL || state_ff == S_DRAIN))
      else $error("scroll write outside scroll sweep");

endmodule

// ===== rtl/core/text_mode_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer
// COLUMNS x ROWS text console with a cell store and a cursor. Puts
// characters, clears the screen and reads cells; one response per command.
//
//   channel   ports                            beat taken when
//   request   start, busy, req_payload         start && !busy
//   response  rsp_strobe, rsp_payload          rsp_strobe (one cycle)
//   register  csr_valid, csr_ready, csr_data   csr_valid && csr_ready
//
// Character and cursor commands respond through the command queue and the
// response register, and run back to back at one per cycle while the engine
// stays idle; reads also pass the read state and the cell store read register.
// A clear or a scroll sweeps every cell through the single write port of the
// cell store; the command queue holds two commands meanwhile, then busy rises.
// After reset busy stays high while the store is filled with blanks; register
// writes are taken throughout.
// Responses cannot be stalled.
// ----------------------------------------------------------------------------
module text_mode_console_writer #(
   parameter int COLUMNS = tmcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tmcw_pkg::DEFAULT_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tmcw_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output tmcw_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import tmcw_pkg::*;

   logic [7:0] attribute_ff;
   logic [7:0] attribute_in;
   logic       push;
   cmd_type    push_cmd;
   logic       q_valid;
   cmd_type    q_cmd;
   logic       q_pop;
   logic       q_full;
   logic       init_active;

   assign csr_ready    = 1'b1;
   assign attribute_in = (csr_valid && csr_ready) ? csr_data : attribute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= RESET_ATTRIBUTE;
      end else begin
         attribute_ff <= attribute_in;
      end
   end

   tmcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .queue_full  (q_full),
      .init_active (init_active),
      .push        (push),
      .cmd         (push_cmd)
   );

   tmcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd),
      .full       (q_full)
   );

   tmcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .attribute   (attribute_ff),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .init_active (init_active),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
